// File: hw/rtl/rqrm_pkg.sv
package rqrm_pkg;

   localparam int ID_WIDTH    = 8;
   localparam int OCC_WIDTH   = 5;
   localparam int QUEUE_DEPTH = 16;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_REMOVE  = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [ID_WIDTH-1:0] process_id;
   } rqrm_req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ID_WIDTH-1:0]  head_id;
      logic [OCC_WIDTH-1:0] occupancy;
      logic                 is_empty;
   } rqrm_rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } rqrm_mem_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DEQ,
      ST_SCAN
   } rqrm_state_type;

endpackage

// File: hw/rtl/rqrm_mem.sv
module rqrm_mem #(
   parameter int QUEUE_DEPTH = rqrm_pkg::QUEUE_DEPTH,
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                           clock,
   input  rqrm_pkg::rqrm_mem_ctl_type     mem_ctl,
   input  logic [PW-1:0]                  rd_addr,
   input  logic [PW-1:0]                  wr_addr,
   input  logic [rqrm_pkg::ID_WIDTH-1:0]  wr_data,
   output logic [rqrm_pkg::ID_WIDTH-1:0]  rd_data
);

   logic [rqrm_pkg::ID_WIDTH-1:0] store_ff [QUEUE_DEPTH];
   logic [rqrm_pkg::ID_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rqrm_ctrl.sv
module rqrm_ctrl #(
   parameter int QUEUE_DEPTH = rqrm_pkg::QUEUE_DEPTH,
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rqrm_pkg::rqrm_req_type         req_data,
   input  logic                           out_free,
   output logic                           done,
   output rqrm_pkg::rqrm_rsp_type         result,
   output rqrm_pkg::rqrm_mem_ctl_type     mem_ctl,
   output logic [PW-1:0]                  rd_addr,
   output logic [PW-1:0]                  wr_addr,
   output logic [rqrm_pkg::ID_WIDTH-1:0]  wr_data,
   input  logic [rqrm_pkg::ID_WIDTH-1:0]  rd_data
);

   localparam int SW = PW + 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
   localparam logic [SW-1:0] DEPTH_S    = SW'(QUEUE_DEPTH);

   rqrm_pkg::rqrm_state_type       state_ff, state_in;
   logic [1:0]                     op_ff, op_in;
   logic [rqrm_pkg::ID_WIDTH-1:0]  id_ff, id_in;
   logic [PW-1:0]                  head_ff, head_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic                           found_ff, found_in;
   logic                           last;
   logic                           hit;

   function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = {1'b0, base} + SW'(off);
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[PW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rqrm_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      id_ff  <= id_in;
      idx_ff <= idx_in;
   end

   assign req_stall = (state_ff != rqrm_pkg::ST_IDLE);
   assign last      = (idx_ff == count_ff - CW'(1));
   assign hit       = (rd_data == id_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      mem_ctl        = '0;
      rd_addr        = phys(head_ff, '0);
      wr_addr        = phys(head_ff, count_ff);
      wr_data        = id_ff;
      done           = 1'b0;
      result.status  = rqrm_pkg::STATUS_DONE;
      result.head_id = '0;
      unique case (state_ff)
         rqrm_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.req_type;
               id_in    = req_data.process_id;
               state_in = rqrm_pkg::ST_EXEC;
            end
         end
         rqrm_pkg::ST_EXEC: begin
            unique case (op_ff)
               rqrm_pkg::OP_ENQUEUE: begin
                  if (out_free) begin
                     done     = 1'b1;
                     state_in = rqrm_pkg::ST_IDLE;
                     if (count_ff == FULL_COUNT) begin
                        result.status = rqrm_pkg::STATUS_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        count_in      = count_ff + CW'(1);
                     end
                  end
               end
               rqrm_pkg::OP_DEQUEUE: begin
                  if (count_ff == '0) begin
                     if (out_free) begin
                        done          = 1'b1;
                        result.status = rqrm_pkg::STATUS_EMPTY;
                        state_in      = rqrm_pkg::ST_IDLE;
                     end
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     state_in      = rqrm_pkg::ST_DEQ;
                  end
               end
               rqrm_pkg::OP_REMOVE: begin
                  if (count_ff == '0) begin
                     if (out_free) begin
                        done          = 1'b1;
                        result.status = rqrm_pkg::STATUS_NOT_FOUND;
                        state_in      = rqrm_pkg::ST_IDLE;
                     end
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     idx_in        = '0;
                     found_in      = 1'b0;
                     state_in      = rqrm_pkg::ST_SCAN;
                  end
               end
               default: begin
                  if (out_free) begin
                     done     = 1'b1;
                     state_in = rqrm_pkg::ST_IDLE;
                  end
               end
            endcase
         end
         rqrm_pkg::ST_DEQ: begin
            if (out_free) begin
               done           = 1'b1;
               result.head_id = rd_data;
               head_in        = phys(head_ff, CW'(1));
               count_in       = count_ff - CW'(1);
               state_in       = rqrm_pkg::ST_IDLE;
            end
         end
         rqrm_pkg::ST_SCAN: begin
            if (!last || out_free) begin
               if (found_ff) begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = phys(head_ff, idx_ff - CW'(1));
                  wr_data       = rd_data;
               end
               if (!last) begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = phys(head_ff, idx_ff + CW'(1));
                  idx_in        = idx_ff + CW'(1);
                  found_in      = found_ff | hit;
               end else begin
                  done     = 1'b1;
                  state_in = rqrm_pkg::ST_IDLE;
                  if (found_ff || hit) begin
                     count_in = count_ff - CW'(1);
                  end else begin
                     result.status = rqrm_pkg::STATUS_NOT_FOUND;
                  end
               end
            end
         end
         default: begin
            state_in = rqrm_pkg::ST_IDLE;
         end
      endcase
      result.occupancy = rqrm_pkg::OCC_WIDTH'(count_in);
      result.is_empty  = (count_in == '0);
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("occupancy above depth");

   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done |-> out_free)
      else $error("result produced into busy output register");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write to the same entry in one cycle");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (done && result.status == rqrm_pkg::STATUS_FULL) |-> (count_ff == FULL_COUNT))
      else $error("full reported on a queue with room");

   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rqrm_pkg::ST_SCAN && found_ff) |-> (idx_ff != '0))
      else $error("shift towards an entry before the head");
`endif

endmodule

// File: hw/rtl/ready_queue_with_remove_by_id.sv
// Ready queue of process ids with enqueue, dequeue and remove-by-id.
// Input channel req_valid / req_stall / req_data carries one request item:
// req_type (enqueue, dequeue, remove) and process_id. Result channel
// rsp_valid / rsp_stall / rsp_data returns exactly one item per request:
// status, head_id, occupancy after the request and is_empty.
// Entries sit in a ring buffer held in a single-port-read, single-port-write
// synchronous RAM; removal shifts later entries one place towards the head.
// Enqueue and rejected requests finish in ST_EXEC; dequeue reads the RAM in
// ST_EXEC and returns the head from ST_DEQ; remove on a non-empty queue
// walks every entry in ST_SCAN, one RAM read per scanned entry. One request
// is in work at a time; the next is accepted the cycle after the result is
// loaded into the output register, so a new request is not taken before the
// last one is through.
// Reset empties the queue at once; no clearing pass is needed.
// While rsp_stall is high the result item is held; a request can still be
// accepted and worked on until it needs the output register, then it waits.
module ready_queue_with_remove_by_id #(
   parameter int QUEUE_DEPTH = rqrm_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rqrm_pkg::rqrm_req_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rqrm_pkg::rqrm_rsp_type  rsp_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   rqrm_pkg::rqrm_mem_ctl_type     mem_ctl;
   logic [PW-1:0]                  rd_addr;
   logic [PW-1:0]                  wr_addr;
   logic [rqrm_pkg::ID_WIDTH-1:0]  wr_data;
   logic [rqrm_pkg::ID_WIDTH-1:0]  rd_data;
   logic                           done;
   logic                           out_free;
   rqrm_pkg::rqrm_rsp_type         result;
   logic                           rsp_valid_ff;
   rqrm_pkg::rqrm_rsp_type         rsp_data_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   rqrm_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .mem_ctl   (mem_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   rqrm_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: verif/ready_queue_with_remove_by_id_tb.sv
`timescale 1ns / 100ps

module ready_queue_with_remove_by_id_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 1025;
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_LIMIT   = 4000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   rqrm_pkg::rqrm_req_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rqrm_pkg::rqrm_rsp_type rsp_data;

   rqrm_pkg::rqrm_req_type        pending_reqs[$];
   rqrm_pkg::rqrm_rsp_type        expected_rsps[$];
   logic [rqrm_pkg::ID_WIDTH-1:0] ready_ids[$];

   int total_items   = 0;
   int accepted_reqs = 0;
   int fail_count    = 0;
   int quiet_cycles  = 0;
   int send_idle_pct;
   int recv_idle_pct;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;

   ready_queue_with_remove_by_id uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic rqrm_pkg::rqrm_rsp_type predict_rsp(rqrm_pkg::rqrm_req_type item);
      rqrm_pkg::rqrm_rsp_type res;
      res = '0;
      res.status = rqrm_pkg::STATUS_DONE;
      case (item.req_type)
         rqrm_pkg::OP_ENQUEUE: begin
            if (ready_ids.size() >= rqrm_pkg::QUEUE_DEPTH)
               res.status = rqrm_pkg::STATUS_FULL;
            else ready_ids.push_back(item.process_id);
         end
         rqrm_pkg::OP_DEQUEUE: begin
            if (ready_ids.size() == 0) res.status = rqrm_pkg::STATUS_EMPTY;
            else res.head_id = ready_ids.pop_front();
         end
         rqrm_pkg::OP_REMOVE: begin
            res.status = rqrm_pkg::STATUS_NOT_FOUND;
            for (int k = 0; k < ready_ids.size(); k++) begin
               if (ready_ids[k] == item.process_id) begin
                  ready_ids.delete(k);
                  res.status = rqrm_pkg::STATUS_DONE;
                  break;
               end
            end
         end
         default: ;
      endcase
      res.occupancy = rqrm_pkg::OCC_WIDTH'(ready_ids.size());
      res.is_empty  = (ready_ids.size() == 0);
      return res;
   endfunction

   function automatic rqrm_pkg::rqrm_req_type make_req(logic [1:0] op,
                                                       logic [rqrm_pkg::ID_WIDTH-1:0] id);
      rqrm_pkg::rqrm_req_type item;
      item.req_type   = op;
      item.process_id = id;
      return item;
   endfunction

   always_comb begin
      if (accepted_reqs < total_items / 3) begin
         send_idle_pct = 31;
         recv_idle_pct = 58;
      end else if (accepted_reqs < (2 * total_items) / 3) begin
         send_idle_pct = 58;
         recv_idle_pct = 31;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_fire) begin
            expected_rsps.push_back(predict_rsp(req_data));
            accepted_reqs <= accepted_reqs + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rqrm_pkg::rqrm_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         if (rsp_fire) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result item status %0d head_id %0d occupancy %0d",
                      rsp_data.status, rsp_data.head_id, rsp_data.occupancy);
               fail_count = fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.head_id !== want.head_id) begin
                  $error("head_id expected %0d actual %0d", want.head_id, rsp_data.head_id);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  $error("occupancy expected %0d actual %0d",
                         want.occupancy, rsp_data.occupancy);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.is_empty !== want.is_empty) begin
                  $error("is_empty expected %0d actual %0d", want.is_empty, rsp_data.is_empty);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_fire || rsp_fire) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      logic [rqrm_pkg::ID_WIDTH-1:0] recent_ids[$];
      logic [rqrm_pkg::ID_WIDTH-1:0] id;
      logic [1:0]                    op;
      int                            mood;
      int                            roll;
      int                            enq_pct;
      int                            deq_pct;

      // empty-queue cases and the unused code
      pending_reqs.push_back(make_req(rqrm_pkg::OP_DEQUEUE, 8'h3C));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_REMOVE, 8'h00));
      pending_reqs.push_back(make_req(OP_UNUSED, 8'hFF));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_ENQUEUE, 8'h00));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_ENQUEUE, 8'hFF));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_ENQUEUE, 8'hA5));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_ENQUEUE, 8'h5A));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_ENQUEUE, 8'hA5));
      // duplicate: only the one nearest the head goes
      pending_reqs.push_back(make_req(rqrm_pkg::OP_REMOVE, 8'hA5));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_REMOVE, 8'h77));
      pending_reqs.push_back(make_req(OP_UNUSED, 8'h00));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_DEQUEUE, 8'hFF));
      // fill to capacity, then overflow
      for (int k = 0; k < 13; k++)
         pending_reqs.push_back(make_req(rqrm_pkg::OP_ENQUEUE, 8'(8'h10 + k)));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_ENQUEUE, 8'hEE));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_REMOVE, 8'h1C));
      pending_reqs.push_back(make_req(rqrm_pkg::OP_REMOVE, 8'hFF));

      mood = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 20 == 0) mood = $urandom_range(0, 2);
         case (mood)
            0:       begin enq_pct = 65; deq_pct = 80; end
            1:       begin enq_pct = 20; deq_pct = 65; end
            default: begin enq_pct = 40; deq_pct = 70; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < enq_pct) op = rqrm_pkg::OP_ENQUEUE;
         else if (roll < deq_pct) op = rqrm_pkg::OP_DEQUEUE;
         else if (roll < 97) op = rqrm_pkg::OP_REMOVE;
         else op = OP_UNUSED;

         if ($urandom_range(0, 99) < 60) id = rqrm_pkg::ID_WIDTH'($urandom_range(0, 15));
         else id = rqrm_pkg::ID_WIDTH'($urandom_range(0, 255));
         if (op == rqrm_pkg::OP_ENQUEUE) begin
            recent_ids.push_back(id);
            if (recent_ids.size() > 32) void'(recent_ids.pop_front());
         end else if (op == rqrm_pkg::OP_REMOVE && recent_ids.size() != 0
                      && $urandom_range(0, 99) < 70) begin
            id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
         end
         pending_reqs.push_back(make_req(op, id));
      end
      total_items = pending_reqs.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // hold until every item is in and every result is back
      @(negedge clock);
      while (accepted_reqs != total_items || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
